>>> rtl/core/glyph_text_layout_top_defines.svh
// Assertion macros shared by the glyph text layout RTL.
`ifndef GLYPH_TEXT_LAYOUT_TOP_DEFINES_SVH
`define GLYPH_TEXT_LAYOUT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gtl_pkg.sv
// Types and constants of the glyph text layout block.
`default_nettype none

package gtl_pkg;

    // Request opcodes carried in s_tuser.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CHAR = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Result kinds carried in m_tuser.
    typedef enum logic [2:0] {
        KIND_QUAD    = 3'd0,
        KIND_SPACE   = 3'd1,
        KIND_NEWLINE = 3'd2,
        KIND_MISSING = 3'd3,
        KIND_MEAS    = 3'd4
    } kind_t;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_SCALE        = 3'd0;
    localparam logic [2:0] REG_LETTER_SPACE = 3'd1;
    localparam logic [2:0] REG_LINE_MODE    = 3'd2;
    localparam logic [2:0] REG_BASE_SIZE    = 3'd3;
    localparam logic [2:0] REG_GUI_COORDS   = 3'd4;

    // Line spacing modes; the other codes behave as one and a half.
    localparam logic [1:0] LINE_SINGLE = 2'd0;
    localparam logic [1:0] LINE_DOUBLE = 2'd2;

    // Special character codes.
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    // Reset values of the configuration registers.
    localparam logic [15:0]        SCALE_RST      = 16'd256;
    localparam logic signed [11:0] LETTER_SP_RST  = 12'sd0;
    localparam logic [1:0]         LINE_MODE_RST  = 2'd1;
    localparam logic [7:0]         BASE_SIZE_RST  = 8'd16;
    localparam logic               GUI_COORDS_RST = 1'b1;

    // Values derived from the reset configuration.
    localparam logic [23:0] BASE_PROD_RST  = 24'd4096;  // base_size * scale
    localparam logic [19:0] FIRST_LINE_RST = 20'd256;   // one scaled base line
    localparam logic [21:0] LINE_STEP_RST  = 22'd384;   // one and a half lines

    // Field widths fixed by the stream format.
    localparam int ATLAS_PORT_BITS = 12;
    localparam int S_TDATA_BITS    = 80;
    localparam int M_TDATA_BITS    = 160;

    localparam logic signed [19:0] PEN_MAX  = 20'sd524287;
    localparam logic signed [19:0] PEN_MIN  = -20'sd524288;
    localparam logic [19:0]        U20_MAX  = 20'hFFFFF;
    localparam logic [18:0]        MEAS_MAX = 19'h7FFFF;

    // Glyph metrics as held in the table.
    typedef struct packed {
        logic [7:0]        adv;
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [8:0] offx;
        logic signed [8:0] offy;
    } glyph_meta_t;

    // Saturate a wide signed sum to the 20-bit pen range.
    function automatic logic signed [19:0] sat_pen(input logic signed [24:0] v);
        logic signed [19:0] r;
        if (v > 25'(PEN_MAX)) begin
            r = PEN_MAX;
        end else if (v < 25'(PEN_MIN)) begin
            r = PEN_MIN;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

    // Clamp an unsigned 20-bit value to the 19-bit measurement range.
    function automatic logic [18:0] clamp_meas(input logic [19:0] v);
        logic [18:0] r;
        if (v > 20'(MEAS_MAX)) begin
            r = MEAS_MAX;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/glyph_text_layout_top.sv
// Glyph text layout: glyph table, scaling pipeline and pen state.
//
// The block lays out a byte string with a bitmap font. Requests arrive on the
// s_ stream: s_tuser carries the opcode (load glyph, lay out character, end
// string) and s_tdata the character code and, for a load, the glyph metrics and
// atlas position. A load writes the glyph table and gives no result. A character
// gives one result on the m_ stream: a placed quad, a space advance, a newline
// or a missing glyph flag. An end request gives the measured width and height of
// the string and clears the pen. m_tuser carries the result kind.
// The APB port sets scale, letter spacing, line spacing mode, base size and the
// coordinate convention; the user must write it only while no request is in
// flight, which the block itself does not enforce. Throughput is one request per
// clock cycle, loads included, while the receiver does not stall. A result
// reaches m_tvalid through three registers after its request is accepted: the
// registered glyph table read, the scaling multipliers, and the pen update into
// the output register. The pen update is the only loop that carries state from
// one request to the next, and it closes within the pen stage. When the receiver
// stalls, the three stages fill up; s_tready stays high until all hold a request.
// Reset marks every glyph table entry as not loaded, clears the pen and the
// widest line, and restores the default configuration; no clearing pass runs.
`default_nettype none

`include "glyph_text_layout_top_defines.svh"

module glyph_text_layout_top #(
    parameter int TABLE_ENTRIES    = 256,
    parameter int ATLAS_COORD_BITS = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: char_code[7:0], glyph_advance[7:0], glyph_width[7:0],
    // glyph_height[7:0], glyph_offset_x[8:0], glyph_offset_y[8:0],
    // atlas_x[11:0], atlas_y[11:0], zero fill to 80 bits.
    input  wire logic [gtl_pkg::S_TDATA_BITS-1:0] s_tdata,
    // s_tuser: opcode[1:0].
    input  wire logic [1:0]  s_tuser,

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0: quad_x[19:0], quad_y[19:0], quad_w[19:0], quad_h[19:0],
    // src_x[11:0], src_y[11:0], src_w[7:0], src_h[7:0], measured_width[18:0],
    // measured_height[18:0], zero fill to 160 bits.
    output logic [gtl_pkg::M_TDATA_BITS-1:0] m_tdata,
    // m_tuser: kind[2:0].
    output logic [2:0]       m_tuser,

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    // Atlas coordinates are stored at the narrower of the configured width and
    // the 12 bits that the stream carries.
    localparam int AW = (ATLAS_COORD_BITS < gtl_pkg::ATLAS_PORT_BITS) ?
                        ATLAS_COORD_BITS : gtl_pkg::ATLAS_PORT_BITS;

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic [1:0]        in_op;
    logic [7:0]        in_code;
    logic [11:0]       in_atlas_x;
    logic [11:0]       in_atlas_y;
    gtl_pkg::glyph_meta_t in_meta;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;
    logic              in_acc;

    assign in_op        = s_tuser;
    assign in_code      = s_tdata[7:0];
    assign in_meta.adv  = s_tdata[15:8];
    assign in_meta.w    = s_tdata[23:16];
    assign in_meta.h    = s_tdata[31:24];
    assign in_meta.offx = s_tdata[40:32];
    assign in_meta.offy = s_tdata[49:41];
    assign in_atlas_x   = s_tdata[61:50];
    assign in_atlas_y   = s_tdata[73:62];
    assign in_idx       = in_code[IDX_W-1:0];
    assign in_range     = ({1'b0, in_code} < 9'(TABLE_ENTRIES));
    assign in_acc       = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        scale_reg;
    logic signed [11:0] letter_sp_reg;
    logic [1:0]         line_mode_reg;
    logic [7:0]         base_size_reg;
    logic               gui_coords_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= gtl_pkg::SCALE_RST;
            letter_sp_reg  <= gtl_pkg::LETTER_SP_RST;
            line_mode_reg  <= gtl_pkg::LINE_MODE_RST;
            base_size_reg  <= gtl_pkg::BASE_SIZE_RST;
            gui_coords_reg <= gtl_pkg::GUI_COORDS_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                gtl_pkg::REG_SCALE:        scale_reg      <= pwdata[15:0];
                gtl_pkg::REG_LETTER_SPACE: letter_sp_reg  <= pwdata[11:0];
                gtl_pkg::REG_LINE_MODE:    line_mode_reg  <= pwdata[1:0];
                gtl_pkg::REG_BASE_SIZE:    base_size_reg  <= pwdata[7:0];
                gtl_pkg::REG_GUI_COORDS:   gui_coords_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            gtl_pkg::REG_SCALE:        prdata = 32'(scale_reg);
            gtl_pkg::REG_LETTER_SPACE: prdata = 32'(letter_sp_reg);
            gtl_pkg::REG_LINE_MODE:    prdata = 32'(line_mode_reg);
            gtl_pkg::REG_BASE_SIZE:    prdata = 32'(base_size_reg);
            gtl_pkg::REG_GUI_COORDS:   prdata = 32'(gui_coords_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // Line metrics trail a write via base_prod_reg, then first_line_reg/line_step_reg.
    // The first item that uses them reaches the pen stage late enough to see them.
    logic [23:0] base_prod_reg;
    logic [19:0] first_line_reg;
    logic [21:0] line_step_reg;
    logic [25:0] step_prod;
    logic [26:0] step_rnd;
    logic [24:0] first_rnd;

    always_comb
    begin
        case (line_mode_reg)
            gtl_pkg::LINE_SINGLE: step_prod = {1'b0, base_prod_reg, 1'b0};
            gtl_pkg::LINE_DOUBLE: step_prod = {base_prod_reg, 2'b00};
            default:              step_prod = 26'(base_prod_reg) +
                                              26'({base_prod_reg, 1'b0});
        endcase
    end

    assign step_rnd  = 27'(step_prod) + 27'd16;
    assign first_rnd = 25'(base_prod_reg) + 25'd8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_prod_reg  <= gtl_pkg::BASE_PROD_RST;
            first_line_reg <= gtl_pkg::FIRST_LINE_RST;
            line_step_reg  <= gtl_pkg::LINE_STEP_RST;
        end
        else
        begin
            base_prod_reg  <= base_size_reg * scale_reg;
            // The scaled base line never exceeds 20 bits.
            first_line_reg <= first_rnd[23:4];
            line_step_reg  <= step_rnd[26:5];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enables: each stage moves when the one ahead has room.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic en_out;
    logic en2;
    logic en1;

    assign en_out   = !out_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;

    // ------------------------------------------------------------------
    // Glyph table: valid bits in flops, metrics and atlas in memories.
    // A load writes at its accept edge, so any later request reads it.
    // ------------------------------------------------------------------
    gtl_pkg::glyph_meta_t metrics_mem [TABLE_ENTRIES];
    logic [2*AW-1:0]      atlas_mem   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                 load_we;

    assign load_we = in_acc && (in_op == gtl_pkg::OP_LOAD) && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load_we)
        begin
            valid_reg[in_idx] <= 1'b1;
        end
    end

    gtl_pkg::glyph_meta_t meta_rd_reg;
    logic [2*AW-1:0]      atlas_rd_reg;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            metrics_mem[in_idx] <= in_meta;
            atlas_mem[in_idx]   <= {in_atlas_y[AW-1:0], in_atlas_x[AW-1:0]};
        end
        if (in_acc)
        begin
            meta_rd_reg  <= metrics_mem[in_idx];
            atlas_rd_reg <= atlas_mem[in_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: table data is available; classify and scale.
    // ------------------------------------------------------------------
    logic [1:0] s1_op_reg;
    logic [7:0] s1_code_reg;
    logic       s1_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= in_acc &&
                            (in_op == gtl_pkg::OP_CHAR || in_op == gtl_pkg::OP_END);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_op_reg   <= in_op;
            s1_code_reg <= in_code;
            s1_hit_reg  <= in_range && valid_reg[in_idx];
        end
    end

    gtl_pkg::kind_t     s1_kind;
    logic signed [16:0] scale_s;
    logic [7:0]         base_adv;
    logic signed [25:0] offx_prod;
    logic signed [25:0] offy_prod;
    logic signed [25:0] offx_rnd;
    logic signed [25:0] offy_rnd;
    logic [23:0]        w_prod;
    logic [23:0]        h_prod;
    logic [23:0]        adv_prod;
    logic [23:0]        w_rnd;
    logic [23:0]        h_rnd;
    logic [23:0]        adv_rnd;

    always_comb
    begin
        if (s1_op_reg == gtl_pkg::OP_END)
        begin
            s1_kind = gtl_pkg::KIND_MEAS;
        end
        else if (s1_code_reg == gtl_pkg::CODE_NEWLINE)
        begin
            s1_kind = gtl_pkg::KIND_NEWLINE;
        end
        else if (!s1_hit_reg)
        begin
            s1_kind = gtl_pkg::KIND_MISSING;
        end
        else if (s1_code_reg == gtl_pkg::CODE_SPACE)
        begin
            s1_kind = gtl_pkg::KIND_SPACE;
        end
        else
        begin
            s1_kind = gtl_pkg::KIND_QUAD;
        end
    end

    // Scaling is round(v * scale / 16), half up; the shift of a signed value
    // after adding half rounds toward plus infinity as required. The unsigned
    // products stay below 2^24 even after the rounding term.
    assign scale_s   = signed'({1'b0, scale_reg});
    assign base_adv  = (meta_rd_reg.adv != 8'd0) ? meta_rd_reg.adv : meta_rd_reg.w;
    assign offx_prod = meta_rd_reg.offx * scale_s;
    assign offy_prod = meta_rd_reg.offy * scale_s;
    assign offx_rnd  = offx_prod + 26'sd8;
    assign offy_rnd  = offy_prod + 26'sd8;
    assign w_prod    = meta_rd_reg.w * scale_reg;
    assign h_prod    = meta_rd_reg.h * scale_reg;
    assign adv_prod  = base_adv * scale_reg;
    assign w_rnd     = w_prod + 24'd8;
    assign h_rnd     = h_prod + 24'd8;
    assign adv_rnd   = adv_prod + 24'd8;

    // ------------------------------------------------------------------
    // Stage 2: scaled values; the pen update closes here.
    // ------------------------------------------------------------------
    gtl_pkg::kind_t     s2_kind_reg;
    logic signed [21:0] sc_offx_reg;
    logic signed [21:0] sc_offy_reg;
    logic [19:0]        sc_w_reg;
    logic [19:0]        sc_h_reg;
    logic [19:0]        sc_adv_reg;
    logic [7:0]         s2_w_reg;
    logic [7:0]         s2_h_reg;
    logic [2*AW-1:0]    s2_atlas_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_kind_reg  <= s1_kind;
            sc_offx_reg  <= offx_rnd[25:4];
            sc_offy_reg  <= offy_rnd[25:4];
            sc_w_reg     <= w_rnd[23:4];
            sc_h_reg     <= h_rnd[23:4];
            sc_adv_reg   <= adv_rnd[23:4];
            s2_w_reg     <= meta_rd_reg.w;
            s2_h_reg     <= meta_rd_reg.h;
            s2_atlas_reg <= atlas_rd_reg;
        end
    end

    // Pen state.
    logic signed [19:0] pen_x_reg;
    logic signed [19:0] pen_y_reg;
    logic [19:0]        widest_reg;
    logic [19:0]        text_h_reg;
    logic signed [19:0] pen_x_next;
    logic signed [19:0] pen_y_next;
    logic [19:0]        widest_next;
    logic [19:0]        text_h_next;

    logic signed [24:0] adv_sum;
    logic signed [24:0] qx_sum;
    logic signed [24:0] qy_sum;
    logic signed [24:0] line_sum;
    logic [22:0]        text_h_sum;
    logic signed [19:0] pen_adv;
    logic [19:0]        widest_upd;

    assign adv_sum    = 25'(pen_x_reg) + signed'({5'b0, sc_adv_reg}) + 25'(letter_sp_reg);
    assign qx_sum     = 25'(pen_x_reg) + 25'(sc_offx_reg);
    assign qy_sum     = 25'(pen_y_reg) + 25'(sc_offy_reg);
    assign line_sum   = gui_coords_reg ?
                        25'(pen_y_reg) + signed'({3'b0, line_step_reg}) :
                        25'(pen_y_reg) - signed'({3'b0, line_step_reg});
    assign text_h_sum = 23'(text_h_reg) + 23'(line_step_reg);
    assign pen_adv    = gtl_pkg::sat_pen(adv_sum);
    // A line ending right of everything seen so far widens the text.
    assign widest_upd = (pen_x_reg > 20'sd0 && $unsigned(pen_x_reg) > widest_reg) ?
                        $unsigned(pen_x_reg) : widest_reg;

    // Result fields.
    logic signed [19:0] o_qx;
    logic signed [19:0] o_qy;
    logic [19:0]        o_qw;
    logic [19:0]        o_qh;
    logic [11:0]        o_sx;
    logic [11:0]        o_sy;
    logic [7:0]         o_sw;
    logic [7:0]         o_sh;
    logic [18:0]        o_mw;
    logic [18:0]        o_mh;

    always_comb
    begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        widest_next = widest_reg;
        text_h_next = text_h_reg;
        o_qx = '0;
        o_qy = '0;
        o_qw = '0;
        o_qh = '0;
        o_sx = '0;
        o_sy = '0;
        o_sw = '0;
        o_sh = '0;
        o_mw = '0;
        o_mh = '0;
        case (s2_kind_reg)
            gtl_pkg::KIND_QUAD:
            begin
                o_qx = gtl_pkg::sat_pen(qx_sum);
                o_qy = gui_coords_reg ? gtl_pkg::sat_pen(qy_sum) : pen_y_reg;
                o_qw = sc_w_reg;
                o_qh = sc_h_reg;
                o_sx = 12'(s2_atlas_reg[AW-1:0]);
                o_sy = 12'(s2_atlas_reg[2*AW-1:AW]);
                o_sw = s2_w_reg;
                o_sh = s2_h_reg;
                pen_x_next = pen_adv;
            end
            gtl_pkg::KIND_SPACE:
            begin
                pen_x_next = pen_adv;
                o_qx = pen_adv;
                o_qy = pen_y_reg;
            end
            gtl_pkg::KIND_NEWLINE:
            begin
                widest_next = widest_upd;
                pen_x_next  = '0;
                pen_y_next  = gtl_pkg::sat_pen(line_sum);
                text_h_next = (text_h_sum > 23'(gtl_pkg::U20_MAX)) ?
                              gtl_pkg::U20_MAX : text_h_sum[19:0];
                o_qy = gtl_pkg::sat_pen(line_sum);
            end
            gtl_pkg::KIND_MISSING:
            begin
                o_qx = pen_x_reg;
                o_qy = pen_y_reg;
            end
            gtl_pkg::KIND_MEAS:
            begin
                o_mw = gtl_pkg::clamp_meas(widest_upd);
                o_mh = gtl_pkg::clamp_meas(text_h_reg);
                pen_x_next  = '0;
                pen_y_next  = '0;
                widest_next = '0;
                text_h_next = first_line_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            widest_reg <= '0;
            text_h_reg <= gtl_pkg::FIRST_LINE_RST;
        end
        else if (en_out && s2_valid_reg)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            widest_reg <= widest_next;
            text_h_reg <= text_h_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [gtl_pkg::M_TDATA_BITS-1:0] out_data_reg;
    logic [gtl_pkg::M_TDATA_BITS-1:0] out_data_next;
    gtl_pkg::kind_t                   out_kind_reg;

    assign out_data_next = {2'b00, o_mh, o_mw, o_sh, o_sw, o_sy, o_sx,
                            o_qh, o_qw, o_qy, o_qx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= s2_kind_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GTL_ASSERT_NEXT(a_load_no_result, clk, rst_n, in_acc && in_op == gtl_pkg::OP_LOAD && en1, !s1_valid_reg, "load request entered the result pipeline")
    `GTL_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !s_tready, m_tvalid && s2_valid_reg && s1_valid_reg, "request refused while the pipeline has room")
    `GTL_ASSERT_NEXT(a_end_clears_pen, clk, rst_n, en_out && s2_valid_reg && s2_kind_reg == gtl_pkg::KIND_MEAS, pen_x_reg == 20'sd0 && pen_y_reg == 20'sd0 && widest_reg == 20'd0, "end of string left pen state behind")
    `GTL_ASSERT_SAME(a_meas_no_quad, clk, rst_n, m_tvalid && m_tuser == gtl_pkg::KIND_MEAS, m_tdata[119:0] == 120'd0, "measurement result carries quad fields")

endmodule

`default_nettype wire
